@@ rtl/ptt_pkg.sv @@
// ptt_pkg: types, codes and fixed widths for the periodic timer table
// depends on: nothing
package ptt_pkg;

    // fixed field widths
    localparam int ID_W      = 16;
    localparam int PERIOD_W  = 20;
    localparam int ELAPSED_W = 16;
    localparam int TIME_W    = 32;

    // expiries reported per tick at most, and a counter that holds that value
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = 5;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // command codes on the input port
    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_KILL = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SET_REPLY  = 2'd0;
    localparam logic [1:0] KIND_KILL_REPLY = 2'd1;
    localparam logic [1:0] KIND_EXPIRY     = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // classified operation
    typedef enum logic [1:0] {
        OP_SET,
        OP_KILL,
        OP_TICK
    } op_t;

    // one queued item
    typedef struct packed {
        op_t                  op;
        logic [ID_W-1:0]      timer_id;
        logic [PERIOD_W-1:0]  period_ms;
        logic [ELAPSED_W-1:0] elapsed_ms;
    } item_t;

    // queue head seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    // one slot memory entry
    typedef struct packed {
        logic [ID_W-1:0]     timer_id;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   deadline;
    } entry_t;

    // one registered result
    typedef struct packed {
        logic            strobe;
        logic [1:0]      kind;
        logic [1:0]      status;
        logic [ID_W-1:0] expired_id;
        logic            last;
    } result_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } back_state_t;

endpackage

@@ rtl/ptt_front.sv @@
// ptt_front: accepts commands, classifies them and queues them for the back end
// depends on: ptt_pkg
module ptt_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     cmd,
    input  logic [ptt_pkg::ID_W-1:0]       timer_id,
    input  logic [ptt_pkg::PERIOD_W-1:0]   period_ms,
    input  logic [ptt_pkg::ELAPSED_W-1:0]  elapsed_ms,
    output ptt_pkg::queue_head_t           head,
    input  logic                           pop
);

    ptt_pkg::item_t                q_mem_reg [ptt_pkg::QUEUE_DEPTH];
    logic [ptt_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [ptt_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [ptt_pkg::QCNT_W-1:0]    count_reg;
    logic [ptt_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [ptt_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [ptt_pkg::QCNT_W-1:0]    count_next;
    logic                          accept;
    logic                          known;
    logic                          push;
    ptt_pkg::item_t                item_in;

    // classify the command, unused codes are dropped
    always_comb
    begin
        item_in.op         = ptt_pkg::OP_TICK;
        item_in.timer_id   = timer_id;
        item_in.period_ms  = period_ms;
        item_in.elapsed_ms = elapsed_ms;
        known              = 1'b1;
        case (cmd)
            ptt_pkg::CMD_SET:  item_in.op = ptt_pkg::OP_SET;
            ptt_pkg::CMD_KILL: item_in.op = ptt_pkg::OP_KILL;
            ptt_pkg::CMD_TICK: item_in.op = ptt_pkg::OP_TICK;
            default:           known      = 1'b0;
        endcase
    end

    assign busy   = (count_reg == ptt_pkg::QCNT_W'(ptt_pkg::QUEUE_DEPTH));
    assign accept = start && !busy;
    assign push   = accept && known;

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            if (wr_ptr_reg == ptt_pkg::QPTR_W'(ptt_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == ptt_pkg::QPTR_W'(ptt_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= item_in;
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem_reg[rd_ptr_reg];

endmodule

@@ rtl/ptt_back.sv @@
// ptt_back: slot table and scan sequencer that carries out set, kill and tick
// depends on: ptt_pkg
module ptt_back
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptt_pkg::queue_head_t  head,
    output logic                  pop,
    output ptt_pkg::result_t      result
);

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SCNT_W = $clog2(NUM_SLOTS + 1);

    // slot memory, one read and one write port
    ptt_pkg::entry_t                  mem [NUM_SLOTS];
    ptt_pkg::entry_t                  rd_entry_reg;
    logic                             mem_re;
    logic [IDX_W-1:0]                 mem_raddr;
    logic                             mem_we;
    logic [IDX_W-1:0]                 mem_waddr;
    ptt_pkg::entry_t                  mem_wdata;

    ptt_pkg::back_state_t             state_reg, state_next;
    ptt_pkg::item_t                   item_reg, item_next;
    logic [ptt_pkg::TIME_W-1:0]       now_reg, now_next;
    logic [NUM_SLOTS-1:0]             valid_reg, valid_next;
    logic [SCNT_W-1:0]                issue_reg, issue_next;
    logic                             pend_reg, pend_next;
    logic [IDX_W-1:0]                 pend_idx_reg, pend_idx_next;
    logic                             hit_reg, hit_next;
    logic [IDX_W-1:0]                 hit_idx_reg, hit_idx_next;
    logic                             free_reg, free_next;
    logic [IDX_W-1:0]                 free_idx_reg, free_idx_next;
    logic                             held_reg, held_next;
    logic [ptt_pkg::ID_W-1:0]         held_id_reg, held_id_next;
    logic [ptt_pkg::RES_CNT_W-1:0]    n_reg, n_next;
    ptt_pkg::result_t                 res_reg, res_next;

    logic                             slot_v;
    logic [ptt_pkg::TIME_W-1:0]       diff;
    logic [ptt_pkg::TIME_W-1:0]       rearm;
    logic [ptt_pkg::TIME_W-1:0]       new_deadline;
    logic                             due;

    // compare stage helpers
    assign slot_v       = valid_reg[pend_idx_reg];
    assign diff         = now_reg - rd_entry_reg.deadline;
    assign rearm        = now_reg + ptt_pkg::TIME_W'(rd_entry_reg.period);
    assign new_deadline = now_reg + ptt_pkg::TIME_W'(item_reg.period_ms);
    assign due          = pend_reg && slot_v && !diff[ptt_pkg::TIME_W-1]
                          && (n_reg < ptt_pkg::RES_CNT_W'(ptt_pkg::MAX_RESULTS));

    // sequencer next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        now_next      = now_reg;
        valid_next    = valid_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        held_next     = held_reg;
        held_id_next  = held_id_reg;
        n_next        = n_reg;
        res_next      = '0;
        pop           = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = issue_reg[IDX_W-1:0];
        mem_we        = 1'b0;
        mem_waddr     = pend_idx_reg;
        mem_wdata     = '{timer_id: rd_entry_reg.timer_id,
                          period:   rd_entry_reg.period,
                          deadline: rearm};

        case (state_reg)
            ptt_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    item_next  = head.item;
                    issue_next = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    held_next  = 1'b0;
                    n_next     = '0;
                    state_next = ptt_pkg::ST_SCAN;
                    if (head.item.op == ptt_pkg::OP_TICK)
                        now_next = now_reg + ptt_pkg::TIME_W'(head.item.elapsed_ms);
                end
            end

            ptt_pkg::ST_SCAN:
            begin
                // issue one slot read per cycle
                if (issue_reg != SCNT_W'(NUM_SLOTS))
                begin
                    mem_re        = 1'b1;
                    issue_next    = issue_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    state_next = ptt_pkg::ST_FINISH;
                end

                // evaluate the slot read in the previous cycle
                case (item_reg.op)
                    ptt_pkg::OP_SET, ptt_pkg::OP_KILL:
                    begin
                        if (pend_reg && slot_v && !hit_reg
                            && (rd_entry_reg.timer_id == item_reg.timer_id))
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = pend_idx_reg;
                        end
                        if (pend_reg && !slot_v && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = pend_idx_reg;
                        end
                    end
                    ptt_pkg::OP_TICK:
                    begin
                        if (due)
                        begin
                            mem_we       = 1'b1;
                            n_next       = n_reg + 1'b1;
                            held_next    = 1'b1;
                            held_id_next = rd_entry_reg.timer_id;
                            // the held expiry is known not to be the final one
                            if (held_reg)
                            begin
                                res_next.strobe     = 1'b1;
                                res_next.kind       = ptt_pkg::KIND_EXPIRY;
                                res_next.status     = ptt_pkg::STATUS_OK;
                                res_next.expired_id = held_id_reg;
                                res_next.last       = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            ptt_pkg::ST_FINISH:
            begin
                state_next          = ptt_pkg::ST_IDLE;
                res_next.expired_id = item_reg.timer_id;
                res_next.last       = 1'b1;
                case (item_reg.op)
                    ptt_pkg::OP_SET:
                    begin
                        res_next.strobe = 1'b1;
                        res_next.kind   = ptt_pkg::KIND_SET_REPLY;
                        if (hit_reg)
                            res_next.status = ptt_pkg::STATUS_MISS;
                        else if (!free_reg)
                            res_next.status = ptt_pkg::STATUS_FULL;
                        else
                        begin
                            res_next.status         = ptt_pkg::STATUS_OK;
                            mem_we                  = 1'b1;
                            mem_waddr               = free_idx_reg;
                            mem_wdata               = '{timer_id: item_reg.timer_id,
                                                        period:   item_reg.period_ms,
                                                        deadline: new_deadline};
                            valid_next[free_idx_reg] = 1'b1;
                        end
                    end
                    ptt_pkg::OP_KILL:
                    begin
                        res_next.strobe = 1'b1;
                        res_next.kind   = ptt_pkg::KIND_KILL_REPLY;
                        if (hit_reg)
                        begin
                            res_next.status         = ptt_pkg::STATUS_OK;
                            valid_next[hit_idx_reg] = 1'b0;
                        end
                        else
                            res_next.status = ptt_pkg::STATUS_MISS;
                    end
                    ptt_pkg::OP_TICK:
                    begin
                        // the held expiry closes the tick
                        res_next.strobe     = held_reg;
                        res_next.kind       = ptt_pkg::KIND_EXPIRY;
                        res_next.status     = ptt_pkg::STATUS_OK;
                        res_next.expired_id = held_id_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            default:
            begin
                state_next = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptt_pkg::ST_IDLE;
            now_reg   <= '0;
            valid_reg <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            held_reg  <= 1'b0;
            n_reg     <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            now_reg   <= now_next;
            valid_reg <= valid_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            held_reg  <= held_next;
            n_reg     <= n_next;
            res_reg   <= res_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pend_idx_reg <= pend_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        held_id_reg  <= held_id_next;
    end

    // slot memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_entry_reg <= mem[mem_raddr];
    end

    assign result = res_reg;

endmodule

@@ rtl/periodic_timer_table_unit.sv @@
// periodic_timer_table_unit: top level of the periodic timer table
// depends on: ptt_pkg, ptt_front, ptt_back
//
// usage
//   command channel: drive cmd, timer_id, period_ms, elapsed_ms with start;
//   an item is taken at a rising edge where start is high and busy is low.
//   cmd 0 sets a timer, 1 kills one, 2 advances the millisecond clock;
//   code 3 is taken and dropped with no result.
//   result channel: strobe marks one result for one cycle on kind, status,
//   expired_id and last; the receiver cannot hold results off.
// timing
//   a two-deep queue parts the front from the back, so busy rises only
//   when two items wait. the back scans the slot memory one slot per
//   cycle and takes the next item only once the last is through; a set
//   or kill reply is registered out of the finish state after the scan.
//   tick expiries leave in slot order during the scan and the finish
//   state, at most one per cycle, the final one flagged by last.
// reset
//   all timers invalid, millisecond clock at zero, queue empty, no strobe.
module periodic_timer_table_unit
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     cmd,
    input  logic [ptt_pkg::ID_W-1:0]       timer_id,
    input  logic [ptt_pkg::PERIOD_W-1:0]   period_ms,
    input  logic [ptt_pkg::ELAPSED_W-1:0]  elapsed_ms,
    output logic                           strobe,
    output logic [1:0]                     kind,
    output logic [1:0]                     status,
    output logic [ptt_pkg::ID_W-1:0]       expired_id,
    output logic                           last
);

    ptt_pkg::queue_head_t  head;
    logic                  pop;
    ptt_pkg::result_t      result;

    // command intake and queue
    ptt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .timer_id   (timer_id),
        .period_ms  (period_ms),
        .elapsed_ms (elapsed_ms),
        .head       (head),
        .pop        (pop)
    );

    // slot table and scan sequencer
    ptt_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

    assign strobe     = result.strobe;
    assign kind       = result.kind;
    assign status     = result.status;
    assign expired_id = result.expired_id;
    assign last       = result.last;

    // the back end only takes an item the queue holds
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from an empty queue");

    // replies to set and kill always close their item
    a_reply_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (kind != ptt_pkg::KIND_EXPIRY)) |-> last)
        else $error("reply without last");

    // an expiry carries no error status
    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (kind == ptt_pkg::KIND_EXPIRY)) |-> (status == ptt_pkg::STATUS_OK))
        else $error("expiry with nonzero status");

    // two final results never come in consecutive cycles
    a_no_back_to_back_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !(strobe && last))
        else $error("final results in consecutive cycles");

endmodule

@@ tb/ptt_tb_pkg.sv @@
`timescale 1ns / 1ps
// ptt_tb_pkg: timer table predictor and result scoreboard for the testbench
// depends on: ptt_pkg
package ptt_tb_pkg;

    import ptt_pkg::*;

    // table size used for the instance and the predictor
    localparam int SLOT_COUNT = 16;

    // command code that the block takes and drops
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // mismatches printed in full, later ones only counted
    localparam int MAX_REPORTS = 10;

    // one result as it appears on the result ports
    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      status;
        logic [ID_W-1:0] timer_id;
        logic            last;
    } timer_result_t;

    class timer_scoreboard;

        // predicted table contents
        logic                slot_armed    [SLOT_COUNT];
        logic [ID_W-1:0]     slot_owner    [SLOT_COUNT];
        logic [PERIOD_W-1:0] slot_period   [SLOT_COUNT];
        logic [TIME_W-1:0]   slot_deadline [SLOT_COUNT];
        logic [TIME_W-1:0]   clock_ms;

        // results still owed by the block, oldest first
        timer_result_t awaited_q[$];

        int items_noted;
        int results_seen;
        int expiries_seen;
        int clock_wraps;
        int mismatches;

        function new();
            foreach (slot_armed[i])
            begin
                slot_armed[i]    = 1'b0;
                slot_owner[i]    = '0;
                slot_period[i]   = '0;
                slot_deadline[i] = '0;
            end
            clock_ms      = '0;
            items_noted   = 0;
            results_seen  = 0;
            expiries_seen = 0;
            clock_wraps   = 0;
            mismatches    = 0;
        endfunction

        // count a failure, print only the first few
        function void flag_failure(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] check failed: %s", $realtime, msg);
        endfunction

        function void await_result(logic [1:0] kind, logic [1:0] status,
                                   logic [ID_W-1:0] id, logic last);
            timer_result_t r;
            r.kind     = kind;
            r.status   = status;
            r.timer_id = id;
            r.last     = last;
            awaited_q  = {awaited_q, r};
        endfunction

        // slot that holds an armed timer with this id, or -1
        function int find_timer(logic [ID_W-1:0] id);
            for (int i = 0; i < SLOT_COUNT; i++)
                if (slot_armed[i] && slot_owner[i] == id)
                    return i;
            return -1;
        endfunction

        // apply one accepted item and queue the results it owes
        function void note_item(logic [1:0] c, logic [ID_W-1:0] id,
                                logic [PERIOD_W-1:0] per, logic [ELAPSED_W-1:0] el);
            int              hit;
            int              free_idx;
            int              fired;
            logic [TIME_W:0] sum;
            logic [TIME_W-1:0] diff;
            items_noted++;
            case (c)
                CMD_SET:
                begin
                    hit = find_timer(id);
                    free_idx = -1;
                    for (int i = 0; i < SLOT_COUNT; i++)
                        if (!slot_armed[i] && free_idx < 0)
                            free_idx = i;
                    // duplicate id wins over a full table
                    if (hit >= 0)
                        await_result(KIND_SET_REPLY, STATUS_MISS, id, 1'b1);
                    else if (free_idx < 0)
                        await_result(KIND_SET_REPLY, STATUS_FULL, id, 1'b1);
                    else
                    begin
                        slot_armed[free_idx]    = 1'b1;
                        slot_owner[free_idx]    = id;
                        slot_period[free_idx]   = per;
                        slot_deadline[free_idx] = clock_ms + per;
                        await_result(KIND_SET_REPLY, STATUS_OK, id, 1'b1);
                    end
                end
                CMD_KILL:
                begin
                    hit = find_timer(id);
                    if (hit < 0)
                        await_result(KIND_KILL_REPLY, STATUS_MISS, id, 1'b1);
                    else
                    begin
                        slot_armed[hit] = 1'b0;
                        await_result(KIND_KILL_REPLY, STATUS_OK, id, 1'b1);
                    end
                end
                CMD_TICK:
                begin
                    // advance the clock, noting a wrap past the top
                    sum = {1'b0, clock_ms} + el;
                    if (sum[TIME_W])
                        clock_wraps++;
                    clock_ms = sum[TIME_W-1:0];
                    fired = 0;
                    // due slots in slot order, wrapping signed compare
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (fired < MAX_RESULTS && slot_armed[i])
                        begin
                            diff = clock_ms - slot_deadline[i];
                            if (!diff[TIME_W-1])
                            begin
                                await_result(KIND_EXPIRY, STATUS_OK, slot_owner[i], 1'b0);
                                slot_deadline[i] = clock_ms + slot_period[i];
                                fired++;
                            end
                        end
                    end
                    if (fired > 0)
                        awaited_q[awaited_q.size() - 1].last = 1'b1;
                end
                default:
                begin
                    // unused code: no state change, no result
                end
            endcase
        endfunction

        // compare one result with the oldest one owed
        function void check_result(logic [1:0] kind, logic [1:0] status,
                                   logic [ID_W-1:0] id, logic last);
            timer_result_t want;
            results_seen++;
            if (kind === KIND_EXPIRY)
                expiries_seen++;
            if (awaited_q.size() == 0)
            begin
                flag_failure($sformatf("unexpected result kind=%0d status=%0d id=%h last=%0d",
                                       kind, status, id, last));
                return;
            end
            want = awaited_q.pop_front();
            if (kind !== want.kind || status !== want.status ||
                id !== want.timer_id || last !== want.last)
                flag_failure({
                    $sformatf("expected kind=%0d status=%0d id=%h last=%0d",
                              want.kind, want.status, want.timer_id, want.last),
                    $sformatf(", got kind=%0d status=%0d id=%h last=%0d",
                              kind, status, id, last)});
        endfunction

        // results never delivered count against the run
        function void close_out();
            if (awaited_q.size() != 0)
                flag_failure($sformatf("%0d results never arrived", awaited_q.size()));
        endfunction

    endclass

endpackage

@@ tb/periodic_timer_table_unit_tb.sv @@
`timescale 1ns / 1ps
// periodic_timer_table_unit_tb: directed and random command items against a predictor
// depends on: ptt_pkg, ptt_tb_pkg, periodic_timer_table_unit
module periodic_timer_table_unit_tb;

    import ptt_pkg::*;
    import ptt_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int DRAIN_CYCLES = 4 * (SLOT_COUNT + 4);
    localparam int POOL_SIZE    = 24;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           cmd;
    logic [ID_W-1:0]      timer_id;
    logic [PERIOD_W-1:0]  period_ms;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 strobe;
    logic [1:0]           kind;
    logic [1:0]           status;
    logic [ID_W-1:0]      expired_id;
    logic                 last;

    timer_scoreboard sb;
    int              sender_idle_pct;
    int              cycle_count;
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    periodic_timer_table_unit #(
        .NUM_SLOTS (SLOT_COUNT)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .timer_id   (timer_id),
        .period_ms  (period_ms),
        .elapsed_ms (elapsed_ms),
        .strobe     (strobe),
        .kind       (kind),
        .status     (status),
        .expired_id (expired_id),
        .last       (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle counter and timeout
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("[periodic_timer_table_unit] ERROR");
        $finish;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(kind, status, expired_id, last);
    end

    // hand one item to the block, with a random gap before it
    task automatic send_item(input logic [1:0] c, input logic [ID_W-1:0] id,
                             input logic [PERIOD_W-1:0] per,
                             input logic [ELAPSED_W-1:0] el);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        cmd        <= c;
        timer_id   <= id;
        period_ms  <= per;
        elapsed_ms <= el;
        start      <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_item(c, id, per, el);
    endtask

    // stop sending and wait for every owed result
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (sb.awaited_q.size() != 0);
    endtask

    // random item: mostly pool ids and short periods so timers fire and collide
    task automatic random_item();
        int                   roll;
        logic [1:0]           c;
        logic [ID_W-1:0]      id;
        logic [PERIOD_W-1:0]  per;
        logic [ELAPSED_W-1:0] el;
        roll = $urandom_range(0, 99);
        if (roll < 32)
            c = CMD_SET;
        else if (roll < 62)
            c = CMD_KILL;
        else if (roll < 96)
            c = CMD_TICK;
        else
            c = CMD_UNUSED;
        if ($urandom_range(0, 99) < 75)
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            id = ID_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 70)
            per = PERIOD_W'($urandom_range(0, 300));
        else if (roll < 85)
            per = '0;
        else
            per = PERIOD_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 75)
            el = ELAPSED_W'($urandom_range(0, 120));
        else if (roll < 85)
            el = '0;
        else
            el = ELAPSED_W'($urandom);
        send_item(c, id, per, el);
    endtask

    // main sequence
    initial
    begin
        sb = new();
        sender_idle_pct = 24;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        cmd        <= CMD_TICK;
        timer_id   <= '0;
        period_ms  <= '0;
        elapsed_ms <= '0;

        // distinct ids for the pool, the extremes first
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            id_pool[k] = ID_W'(k * 2749 + $urandom_range(0, 2000));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, tick with nothing due
        send_item(CMD_TICK, '0, '0, '0);
        // extremes of id and period, then a duplicate
        send_item(CMD_SET, '0, '0, '0);
        send_item(CMD_SET, '1, '1, '0);
        send_item(CMD_SET, '0, 20'd7, '0);
        // largest step: zero-period timer fires, long one does not
        send_item(CMD_TICK, '0, '0, '1);
        // kill hit then miss
        send_item(CMD_KILL, '1, '0, '0);
        send_item(CMD_KILL, '1, '0, '0);
        // unused code with every field at its top
        send_item(CMD_UNUSED, '1, '1, '1);
        // zero step still fires a zero period
        send_item(CMD_TICK, '0, '0, '0);
        // fill the table from the pool
        for (int k = 2; k <= SLOT_COUNT; k++)
            send_item(CMD_SET, id_pool[k], PERIOD_W'((k * 3) % 11), '0);
        // full table refuses a new id, duplicate check still comes first
        send_item(CMD_SET, id_pool[SLOT_COUNT + 1], 20'd4, '0);
        send_item(CMD_SET, '0, 20'd4, '0);
        // every slot due at once
        send_item(CMD_TICK, '0, '0, 16'h8000);

        // random, sender idling often
        repeat (45) random_item();
        drain_results();

        // random, sender idling most of the time
        sender_idle_pct = 78;
        repeat (45) random_item();

        // random, no idling
        sender_idle_pct = 0;
        repeat (45) random_item();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close_out();

        $display("run covered %0d items, %0d results checked, %0d of them expiries",
                 sb.items_noted, sb.results_seen, sb.expiries_seen);
        $display("millisecond clock wrapped %0d time(s), %0d check failures",
                 sb.clock_wraps, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[periodic_timer_table_unit] OK");
        else
            $display("[periodic_timer_table_unit] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ptt_pkg.sv
rtl/ptt_front.sv
rtl/ptt_back.sv
rtl/periodic_timer_table_unit.sv
tb/ptt_tb_pkg.sv
tb/periodic_timer_table_unit_tb.sv
